// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DQR_CHECK_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed: same-cycle rule");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DQR_CHECK_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed: next-cycle rule");

`endif

// ===== rtl/dqr_pkg.sv =====
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared constants, command and status codes, and the beat types passed
// between the front end, the command queue and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dqr_pkg;

    localparam int unsigned DEPTH   = 16;
    localparam int unsigned IDX_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned DATA_W  = 32;

    // Command queue between front and back; must be a power of two.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_DROP_LAST  = 3'd2,
        CMD_DROP_FIRST = 3'd3,
        CMD_REVERSE    = 3'd4,
        CMD_DUMP       = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_PUSH    = 3'd1,
        OP_DROP    = 3'd2,
        OP_REVERSE = 3'd3,
        OP_DUMP    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One classified command. at_front marks the logical-front variant
    // (push front, drop first).
    typedef struct packed {
        op_t                        op;
        logic                       at_front;
        logic signed [DATA_W-1:0]   value;
    } item_t;

    // Control side of one result beat.
    typedef struct packed {
        logic       valid;
        logic       has_data;
        status_t    status;
        logic       last;
    } res_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dqr_front.sv =====
// ----------------------------------------------------------------------------
// dqr_front
// Command intake: accept a command beat and classify it into a queue item.
// ----------------------------------------------------------------------------
`default_nettype none

module dqr_front (
    input  wire logic                               start,
    input  wire logic [2:0]                         cmd,
    input  wire logic signed [dqr_pkg::DATA_W-1:0]  value,
    input  wire logic                               q_full,
    output logic                                    busy,
    output logic                                    q_push,
    output dqr_pkg::item_t                          q_item
);

    assign busy   = q_full;
    assign q_push = start && !q_full;

    always_comb
    begin
        q_item.value    = value;
        q_item.at_front = 1'b0;
        q_item.op       = dqr_pkg::OP_NOP;
        case (cmd)
            dqr_pkg::CMD_PUSH_BACK:
            begin
                q_item.op = dqr_pkg::OP_PUSH;
            end
            dqr_pkg::CMD_PUSH_FRONT:
            begin
                q_item.op       = dqr_pkg::OP_PUSH;
                q_item.at_front = 1'b1;
            end
            dqr_pkg::CMD_DROP_LAST:
            begin
                q_item.op = dqr_pkg::OP_DROP;
            end
            dqr_pkg::CMD_DROP_FIRST:
            begin
                q_item.op       = dqr_pkg::OP_DROP;
                q_item.at_front = 1'b1;
            end
            dqr_pkg::CMD_REVERSE:
            begin
                q_item.op = dqr_pkg::OP_REVERSE;
            end
            dqr_pkg::CMD_DUMP:
            begin
                q_item.op = dqr_pkg::OP_DUMP;
            end
            default:
            begin
                q_item.op = dqr_pkg::OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dqr_cmdq.sv =====
// ----------------------------------------------------------------------------
// dqr_cmdq
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dqr_cmdq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dqr_pkg::item_t push_item,
    input  wire logic           pop,
    output logic                valid,
    output dqr_pkg::item_t      pop_item,
    output logic                full
);

    localparam int unsigned PTR_W = dqr_pkg::Q_PTR_W;
    localparam int unsigned CNT_W = dqr_pkg::Q_CNT_W;

    dqr_pkg::item_t     slot_reg [dqr_pkg::Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_push;
    logic               do_pop;

    assign valid    = (cnt_reg != '0);
    assign full     = (cnt_reg == CNT_W'(dqr_pkg::Q_DEPTH));
    assign pop_item = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointers wrap by overflow since the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dqr_back.sv =====
// ----------------------------------------------------------------------------
// dqr_back
// Execution back end: circular word store with a reverse flag, executes
// queued commands and walks the store one word per cycle for a dump.
// ----------------------------------------------------------------------------
`default_nettype none

module dqr_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    input  wire dqr_pkg::item_t                     q_item,
    output logic                                    q_pop,
    output dqr_pkg::res_ctl_t                       res_ctl,
    output logic signed [dqr_pkg::DATA_W-1:0]       res_data
);

    localparam int unsigned IDX_W  = dqr_pkg::IDX_W;
    localparam int unsigned CNT_W  = dqr_pkg::CNT_W;
    localparam int unsigned SUM_W  = CNT_W + 1;
    localparam int unsigned DATA_W = dqr_pkg::DATA_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(dqr_pkg::DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(dqr_pkg::DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(dqr_pkg::DEPTH);

    typedef enum logic {
        S_RUN,
        S_DUMP
    } state_t;

    // base + off modulo DEPTH; base < DEPTH and off <= DEPTH keep the sum
    // below twice the depth, so one subtract wraps it.
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] slot_dec(input logic [IDX_W-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    logic signed [DATA_W-1:0]   mem [dqr_pkg::DEPTH];
    logic signed [DATA_W-1:0]   rd_data_reg;

    state_t                     state_reg;
    state_t                     state_next;
    logic [IDX_W-1:0]           front_reg;
    logic [IDX_W-1:0]           front_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       rev_reg;
    logic                       rev_next;
    logic [IDX_W-1:0]           dump_slot_reg;
    logic [IDX_W-1:0]           dump_slot_next;
    logic [CNT_W-1:0]           dump_left_reg;
    logic [CNT_W-1:0]           dump_left_next;
    logic                       dump_fwd_reg;
    logic                       dump_fwd_next;
    dqr_pkg::res_ctl_t          emit_reg;
    dqr_pkg::res_ctl_t          emit_next;

    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic                       is_full;
    logic                       is_empty;
    logic                       low_end;
    logic                       dump_last;

    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);
    // Physical low end: logical front in normal order, logical back reversed.
    assign low_end   = q_item.at_front ^ rev_reg;
    assign dump_last = (dump_left_reg == CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        dump_slot_next = dump_slot_reg;
        dump_left_next = dump_left_reg;
        dump_fwd_next  = dump_fwd_reg;
        emit_next      = '0;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wrap_add(front_reg, count_reg);

        case (state_reg)
            S_RUN:
            begin
                if (q_valid)
                begin
                    q_pop            = 1'b1;
                    emit_next.valid  = 1'b1;
                    emit_next.last   = 1'b1;
                    emit_next.status = dqr_pkg::ST_OK;
                    case (q_item.op)
                        dqr_pkg::OP_PUSH:
                        begin
                            if (is_full)
                            begin
                                emit_next.status = dqr_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (low_end)
                                begin
                                    front_next = slot_dec(front_reg);
                                    mem_waddr  = slot_dec(front_reg);
                                end
                            end
                        end
                        dqr_pkg::OP_DROP:
                        begin
                            if (is_empty)
                            begin
                                emit_next.status = dqr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                if (low_end)
                                begin
                                    front_next = slot_inc(front_reg);
                                end
                            end
                        end
                        dqr_pkg::OP_REVERSE:
                        begin
                            rev_next = ~rev_reg;
                        end
                        dqr_pkg::OP_DUMP:
                        begin
                            // An empty dump answers with a lone marker beat.
                            if (!is_empty)
                            begin
                                emit_next      = '0;
                                state_next     = S_DUMP;
                                dump_left_next = count_reg;
                                dump_fwd_next  = ~rev_reg;
                                dump_slot_next = rev_reg
                                               ? wrap_add(front_reg, count_reg - 1'b1)
                                               : front_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // Read data for this slot lands with the emitted beat.
                emit_next.valid    = 1'b1;
                emit_next.has_data = 1'b1;
                emit_next.status   = dqr_pkg::ST_OK;
                emit_next.last     = dump_last;
                dump_left_next     = dump_left_reg - 1'b1;
                dump_slot_next     = dump_fwd_reg ? slot_inc(dump_slot_reg)
                                                  : slot_dec(dump_slot_reg);
                if (dump_last)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            dump_slot_reg <= '0;
            dump_left_reg <= '0;
            dump_fwd_reg  <= 1'b1;
            emit_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            dump_slot_reg <= dump_slot_next;
            dump_left_reg <= dump_left_next;
            dump_fwd_reg  <= dump_fwd_next;
            emit_reg      <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= q_item.value;
        end
        rd_data_reg <= mem[dump_slot_reg];
    end

    assign res_ctl  = emit_reg;
    assign res_data = emit_reg.has_data ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/deque_with_reverse.sv =====
// ----------------------------------------------------------------------------
// deque_with_reverse
// Bounded double-ended store of signed 32-bit words with O(1) reverse.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd/value with start high; the beat is taken at
//   a rising edge where start is high and busy is low. busy rises only when
//   the two-entry command queue is full.
//   Result channel: one beat per cycle at most, marked by result_valid and
//   present for exactly one cycle; the receiver must take it, it cannot
//   stall. last marks the final beat of a command.
//   Push, drop, reverse and unused codes give one status beat. A dump gives
//   one beat per held word, front to back, or one marker beat when empty.
//   A command's first beat, when the back end is free, is registered in the
//   command queue, then in the result stage; a dump's first word also passes
//   the dump state. Throughput: one command per cycle for push/drop/reverse
//   outside a dump; a dump holds the back end to its last word (one store
//   read port, one word per cycle), while the queue takes commands until it fills.
//   Reset: empty store, normal order, queue empty, no beat pending. Store
//   words hold no reset value; only written words are ever read out.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_reverse (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [2:0]                         cmd,
    input  wire logic signed [dqr_pkg::DATA_W-1:0]  value,
    output logic                                    result_valid,
    output logic signed [dqr_pkg::DATA_W-1:0]       data,
    output logic                                    has_data,
    output logic [1:0]                              status,
    output logic                                    last
);

    logic               q_push;
    dqr_pkg::item_t     q_in_item;
    logic               q_full;
    logic               q_valid;
    dqr_pkg::item_t     q_out_item;
    logic               q_pop;
    dqr_pkg::res_ctl_t  res_ctl;

    // Classify the incoming beat and hold busy while the queue is full.
    dqr_front u_front (
        .start  (start),
        .cmd    (cmd),
        .value  (value),
        .q_full (q_full),
        .busy   (busy),
        .q_push (q_push),
        .q_item (q_in_item)
    );

    // Decouple intake from execution so a long dump does not block intake.
    dqr_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_out_item),
        .full      (q_full)
    );

    // Execute commands against the store; every result goes out through
    // one registered beat stage.
    dqr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_out_item),
        .q_pop    (q_pop),
        .res_ctl  (res_ctl),
        .res_data (data)
    );

    assign result_valid = res_ctl.valid;
    assign has_data     = res_ctl.has_data;
    assign status       = res_ctl.status;
    assign last         = res_ctl.last;

endmodule

`default_nettype wire

// ===== rtl/dqr_checker.sv =====
// ----------------------------------------------------------------------------
// dqr_checker
// Port-level checks on the result channel of the deque block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dqr_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               result_valid,
    input  wire logic signed [dqr_pkg::DATA_W-1:0]  data,
    input  wire logic                               has_data,
    input  wire logic [1:0]                         status,
    input  wire logic                               last
);

    // A status beat is always the only beat of its command.
    `DQR_CHECK_IMP(a_status_is_last, clk, rst_n, result_valid && !has_data, last)

    // Refusals never carry a word.
    `DQR_CHECK_IMP(a_err_no_data, clk, rst_n, result_valid && (status != dqr_pkg::ST_OK), !has_data)

    // Data reads zero on any beat without a word.
    `DQR_CHECK_IMP(a_zero_data, clk, rst_n, result_valid && !has_data, data == '0)

    // Dump words stream back to back until the marked last word.
    `DQR_CHECK_NXT(a_dump_contig, clk, rst_n, result_valid && has_data && !last, result_valid && has_data)

endmodule

bind deque_with_reverse dqr_checker u_dqr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .data         (data),
    .has_data     (has_data),
    .status       (status),
    .last         (last)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for deque_with_reverse. A driver feeds push, drop,
// reverse, dump and unused commands from a queue of pending beats. A shadow
// deque, updated on every accepted command, predicts each result beat. A
// monitor checks every result beat field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------

module testbench;

    // Codes 6 and 7 decode to nothing and give a plain status beat.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // Cycles with neither a command nor a result accepted before giving up.
    // A full dump holds the back end until its last word is out. Even at the
    // heaviest sender idling, a quiet stretch stays far below this limit.
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles after the final result: covers the command latency through
    // the queue and the result stage, the dump state and a full queue behind it.
    localparam int DRAIN_CYCLES = 4 * dqr_pkg::DEPTH;

    typedef struct {
        logic [2:0]                         op;
        logic signed [dqr_pkg::DATA_W-1:0]  word;
    } cmd_beat_t;

    typedef struct {
        logic signed [dqr_pkg::DATA_W-1:0]  data;
        logic                               has_data;
        dqr_pkg::status_t                   status;
        logic                               last;
    } result_beat_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [2:0]                         cmd;
    logic signed [dqr_pkg::DATA_W-1:0]  value;
    logic                               result_valid;
    logic signed [dqr_pkg::DATA_W-1:0]  data;
    logic                               has_data;
    logic [1:0]                         status;
    logic                               last;

    cmd_beat_t      pending_cmds[$];
    result_beat_t   expected_beats[$];

    // Shadow copy of the deque: ring of words, index of the lowest held
    // slot, word count and the reverse flag.
    logic signed [dqr_pkg::DATA_W-1:0]  shadow_words [dqr_pkg::DEPTH];
    int                                 shadow_head;
    int                                 shadow_count;
    bit                                 shadow_flipped;

    int     sender_idle_pct;
    bit     beat_open;
    int     quiet_cycles;
    int     mismatch_count;

    deque_with_reverse i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .value        (value),
        .result_valid (result_valid),
        .data         (data),
        .has_data     (has_data),
        .status       (status),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Shadow deque: apply one accepted command and queue the beats it causes.
    // ------------------------------------------------------------------------
    task automatic predict_command(input logic [2:0] op,
                                   input logic signed [dqr_pkg::DATA_W-1:0] word);
        bit             low_end;
        int             slot;
        result_beat_t   beat;
        begin
            beat.data     = '0;
            beat.has_data = 1'b0;
            beat.status   = dqr_pkg::ST_OK;
            beat.last     = 1'b1;
            case (op)
                dqr_pkg::CMD_PUSH_BACK, dqr_pkg::CMD_PUSH_FRONT:
                begin
                    if (shadow_count >= dqr_pkg::DEPTH)
                        beat.status = dqr_pkg::ST_FULL;
                    else
                    begin
                        // Front push in normal order and back push in
                        // reversed order both land below the lowest slot.
                        low_end = (op == dqr_pkg::CMD_PUSH_FRONT) != shadow_flipped;
                        if (low_end)
                        begin
                            shadow_head = (shadow_head + dqr_pkg::DEPTH - 1)
                                        % dqr_pkg::DEPTH;
                            slot = shadow_head;
                        end
                        else
                            slot = (shadow_head + shadow_count) % dqr_pkg::DEPTH;
                        shadow_words[slot] = word;
                        shadow_count++;
                    end
                end
                dqr_pkg::CMD_DROP_LAST, dqr_pkg::CMD_DROP_FIRST:
                begin
                    if (shadow_count == 0)
                        beat.status = dqr_pkg::ST_EMPTY;
                    else
                    begin
                        low_end = (op == dqr_pkg::CMD_DROP_FIRST) != shadow_flipped;
                        if (low_end)
                            shadow_head = (shadow_head + 1) % dqr_pkg::DEPTH;
                        shadow_count--;
                    end
                end
                dqr_pkg::CMD_REVERSE:
                    shadow_flipped = !shadow_flipped;
                dqr_pkg::CMD_DUMP:
                begin
                    // Emit the words front to back; an empty deque falls
                    // through to the single marker beat below.
                    if (shadow_count > 0)
                    begin
                        for (int p = 0; p < shadow_count; p++)
                        begin
                            if (shadow_flipped)
                                slot = (shadow_head + shadow_count - 1 - p)
                                     % dqr_pkg::DEPTH;
                            else
                                slot = (shadow_head + p) % dqr_pkg::DEPTH;
                            beat.data     = shadow_words[slot];
                            beat.has_data = 1'b1;
                            beat.last     = (p == shadow_count - 1);
                            expected_beats.push_back(beat);
                        end
                        return;
                    end
                end
                default:
                    ;
            endcase
            expected_beats.push_back(beat);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_cmd(input logic [2:0] op,
                             input logic signed [dqr_pkg::DATA_W-1:0] word);
        cmd_beat_t item;
        begin
            item.op   = op;
            item.word = word;
            pending_cmds.push_back(item);
        end
    endtask

    // Alternate fill and drain bursts so the deque keeps swinging between
    // full and empty; the payload is random, with the extremes mixed in.
    task automatic queue_random(input int count);
        int                                 burst_left;
        bit                                 filling;
        int                                 roll;
        logic [2:0]                         op;
        logic signed [dqr_pkg::DATA_W-1:0]  word;
        begin
            burst_left = 0;
            filling    = 1'b1;
            for (int n = 0; n < count; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(40, 20);
                    filling    = !filling;
                end
                burst_left--;
                roll = $urandom_range(99);
                if (filling)
                begin
                    if (roll < 35)      op = dqr_pkg::CMD_PUSH_BACK;
                    else if (roll < 70) op = dqr_pkg::CMD_PUSH_FRONT;
                    else if (roll < 77) op = dqr_pkg::CMD_DROP_LAST;
                    else if (roll < 84) op = dqr_pkg::CMD_DROP_FIRST;
                    else if (roll < 90) op = dqr_pkg::CMD_REVERSE;
                    else if (roll < 98) op = dqr_pkg::CMD_DUMP;
                    else                op = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
                end
                else
                begin
                    if (roll < 10)      op = dqr_pkg::CMD_PUSH_BACK;
                    else if (roll < 20) op = dqr_pkg::CMD_PUSH_FRONT;
                    else if (roll < 50) op = dqr_pkg::CMD_DROP_LAST;
                    else if (roll < 80) op = dqr_pkg::CMD_DROP_FIRST;
                    else if (roll < 88) op = dqr_pkg::CMD_REVERSE;
                    else if (roll < 97) op = dqr_pkg::CMD_DUMP;
                    else                op = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
                end
                if ($urandom_range(7) == 0)
                begin
                    case ($urandom_range(3))
                        0:       word = 32'sh7fff_ffff;
                        1:       word = 32'sh8000_0000;
                        2:       word = '0;
                        default: word = '1;
                    endcase
                end
                else
                    word = $urandom;
                queue_cmd(op, word);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present a command beat at the falling edge and hold it until
    // the rising edge that takes it. Each step assigns start at most once.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!beat_open)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                cmd       <= pending_cmds[0].op;
                value     <= pending_cmds[0].word;
                start     <= 1'b1;
                beat_open  = 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take accepted commands into the shadow deque, check result
    // beats, and watch for a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_beat_t   want;
        bit             took_cmd;
        took_cmd = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_command(cmd, value);
                void'(pending_cmds.pop_front());
                beat_open = 1'b0;
                took_cmd  = 1'b1;
            end
            // The receiver cannot stall: every strobed beat is taken here.
            if (result_valid)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: data %0d status %0d last %0b",
                           data, status, last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (data !== want.data)
                    begin
                        $error("data: expected %0d, got %0d", want.data, data);
                        mismatch_count++;
                    end
                    if (has_data !== want.has_data)
                    begin
                        $error("has_data: expected %0b, got %0b", want.has_data, has_data);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        mismatch_count++;
                    end
                end
            end
        end
        if (took_cmd || (rst_n && result_valid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed corners, three random phases with different
    // sender idling, then drain and report.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        cmd             = dqr_pkg::CMD_PUSH_BACK;
        value           = '0;
        beat_open       = 1'b0;
        quiet_cycles    = 0;
        mismatch_count  = 0;
        shadow_head     = 0;
        shadow_count    = 0;
        shadow_flipped  = 1'b0;
        sender_idle_pct = 14;

        // Empty deque: dump marker and both drops refused.
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        queue_cmd(dqr_pkg::CMD_DROP_LAST,  '1);
        queue_cmd(dqr_pkg::CMD_DROP_FIRST, '0);
        // Extreme words at both ends.
        queue_cmd(dqr_pkg::CMD_PUSH_BACK,  32'sh7fff_ffff);
        queue_cmd(dqr_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
        queue_cmd(dqr_pkg::CMD_PUSH_BACK,  '0);
        queue_cmd(dqr_pkg::CMD_PUSH_FRONT, '1);
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        // Reversed order: pushes and drops swap physical ends.
        queue_cmd(dqr_pkg::CMD_REVERSE,    32'sh5555_5555);
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        queue_cmd(dqr_pkg::CMD_PUSH_BACK,  32'sh1234_5678);
        queue_cmd(dqr_pkg::CMD_PUSH_FRONT, 32'sha5a5_a5a5);
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        queue_cmd(dqr_pkg::CMD_DROP_LAST,  '0);
        queue_cmd(dqr_pkg::CMD_DROP_FIRST, '0);
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        // Unused codes only give a status beat.
        queue_cmd(CMD_SPARE_LO,            32'sh0bad_cafe);
        queue_cmd(CMD_SPARE_HI,            '1);
        queue_cmd(dqr_pkg::CMD_REVERSE,    '0);
        queue_cmd(dqr_pkg::CMD_DROP_FIRST, '0);
        queue_cmd(dqr_pkg::CMD_DROP_LAST,  '0);
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        queue_cmd(dqr_pkg::CMD_DROP_LAST,  '0);
        queue_cmd(dqr_pkg::CMD_DROP_FIRST, '0);
        queue_cmd(dqr_pkg::CMD_DUMP,       '0);
        queue_random(90);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() > 0)
            @(negedge clk);
        sender_idle_pct = 63;
        queue_random(110);

        while (pending_cmds.size() > 0)
            @(negedge clk);
        sender_idle_pct = 0;
        queue_random(110);

        while (pending_cmds.size() > 0 || expected_beats.size() > 0)
            @(negedge clk);
        // Hold a while longer so any stray beat shows up as unexpected.
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
